[hdl/dit_pkg.sv]
// Shared types and constants for the decimal integer token parser.
// No dependencies; dit_scan and decimal_int_token_parser import this package.
package dit_pkg;

    // Character codes
    localparam logic [7:0] CHAR_SEP_MAX = 8'd32;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;

    // Magnitude limits of a signed 32-bit value
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    // One input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_arg;
    } char_item_t;

    // One result transaction
    typedef struct packed {
        logic signed [31:0] number;
        logic               bad_token;
    } token_item_t;

    // Token collection state
    typedef struct packed {
        logic        in_token;
        logic        negative;
        logic        sign_seen;
        logic        digit_seen;
        logic        bad_char;
        logic [31:0] magnitude;
        logic        overflowed;
        logic        halted;
    } token_state_t;

endpackage

[hdl/dit_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Used for both the character input and the token result output.
interface dit_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/dit_scan.sv]
// Token scanner: holds the token state and turns one character into at most one result.
// Depends on dit_pkg.
module dit_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  dit_pkg::char_item_t chr,
    output logic                res_valid,
    output dit_pkg::token_item_t res
);
    import dit_pkg::*;

    token_state_t state_reg;
    token_state_t state_next;
    token_state_t upd;
    token_state_t fin_src;

    logic        is_sep;
    logic        is_digit;
    logic        is_sign;
    logic        finish;
    logic        fin_bad;
    logic [35:0] prod;
    logic [35:0] limit;
    logic [3:0]  digit;

    // Classify the character
    assign is_sep   = (chr.char_code <= CHAR_SEP_MAX) || chr.char_code[7];
    assign is_digit = (chr.char_code >= CHAR_ZERO) && (chr.char_code <= CHAR_NINE);
    assign is_sign  = (chr.char_code == CHAR_MINUS) || (chr.char_code == CHAR_PLUS);
    assign digit    = chr.char_code[3:0];

    // Multiply by ten and add the digit
    assign prod  = ({4'b0, state_reg.magnitude} << 3) + ({4'b0, state_reg.magnitude} << 1)
                 + {32'b0, digit};
    assign limit = {4'b0, (state_reg.negative ? NEG_LIMIT : POS_LIMIT)};

    // Fold one non-separator character into the token
    always_comb
    begin
        upd          = state_reg;
        upd.in_token = 1'b1;
        if (is_digit)
        begin
            upd.digit_seen = 1'b1;
            if (prod > limit)
            begin
                upd.overflowed = 1'b1;
                upd.magnitude  = limit[31:0];
            end
            else
            begin
                upd.magnitude = prod[31:0];
            end
        end
        else if (!state_reg.in_token && is_sign)
        begin
            upd.sign_seen = 1'b1;
            upd.negative  = (chr.char_code == CHAR_MINUS);
        end
        else
        begin
            upd.bad_char = 1'b1;
        end
    end

    // Decide whether the token ends, and from which state
    always_comb
    begin
        finish  = 1'b0;
        fin_src = state_reg;
        if (!state_reg.halted)
        begin
            if (is_sep)
            begin
                finish  = state_reg.in_token;
                fin_src = state_reg;
            end
            else
            begin
                finish  = chr.end_of_arg;
                fin_src = upd;
            end
        end
    end

    assign fin_bad = fin_src.bad_char || !fin_src.digit_seen || fin_src.overflowed;

    // Build the result and the next state
    always_comb
    begin
        res_valid     = finish;
        res.bad_token = fin_bad;
        if (fin_bad)
            res.number = '0;
        else if (fin_src.negative)
            res.number = $signed(32'(32'd0 - fin_src.magnitude));
        else
            res.number = $signed(fin_src.magnitude);

        state_next = state_reg;
        if (finish)
        begin
            state_next        = '0;
            state_next.halted = fin_bad;
        end
        else if (!state_reg.halted && !is_sep)
        begin
            state_next = upd;
        end
    end

    // Advance the state on each taken transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (take)
            state_reg <= state_next;
    end

endmodule

[hdl/decimal_int_token_parser.sv]
// Decimal integer token parser: ASCII bytes in, signed 32-bit token values out.
// Each result passes the input register, the multiply-by-ten scan, then the result register.
// Throughput: one input transaction per cycle while the result register is not stalled.
// Reset (rst_n, async, active low): clears the token state, the halt flag and both valid flags.
// After a bad token result, transactions are still accepted but produce nothing until reset.
// Depends on dit_pkg, dit_stream_if and dit_scan.
module decimal_int_token_parser (
    input  logic                clk,
    input  logic                rst_n,
    dit_stream_if.sink          chars,
    dit_stream_if.source        tokens
);
    import dit_pkg::*;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    char_item_t   s1_data_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    token_item_t  out_data_reg;
    logic         s1_adv;
    logic         take;
    logic         res_valid;
    token_item_t  res;

    // Stage one moves on whenever the result register can take a new value
    assign s1_adv      = !out_valid_reg || tokens.ready;
    assign take        = s1_valid_reg && s1_adv;
    assign chars.ready = !s1_valid_reg || s1_adv;

    dit_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .chr       (s1_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (chars.valid && chars.ready)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = take && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payloads; load on transfer
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            s1_data_reg <= chars.payload;
        if (s1_adv)
            out_data_reg <= res;
    end

    assign tokens.valid   = out_valid_reg;
    assign tokens.payload = out_data_reg;

endmodule
